/* rtl/ccm_pkg.sv */
// Shared types, widths and operation codes for the CIGAR coordinate mapper.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package ccm_pkg;

   localparam int MAX_OPS     = 256;
   localparam int OP_IDX_W    = $clog2(MAX_OPS);
   localparam int OP_CNT_W    = $clog2(MAX_OPS + 1);
   localparam int COORD_W     = 31;
   localparam int LEN_W       = 28;
   localparam int KIND_W      = 4;
   // running offsets: MAX_OPS lengths of LEN_W bits, plus one guard bit
   localparam int OFS_W       = LEN_W + OP_IDX_W + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REF_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_END   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_QRY_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_QRY_END   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OP_COUNT  = 3'd5;

   // CIGAR operation kinds
   localparam logic [KIND_W-1:0] KIND_M    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_I    = 4'd1;
   localparam logic [KIND_W-1:0] KIND_D    = 4'd2;
   localparam logic [KIND_W-1:0] KIND_N    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_S    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_EQ   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_X    = 4'd8;

   typedef struct packed {
      logic [COORD_W-1:0]  ref_start;
      logic [COORD_W-1:0]  ref_end;
      logic [COORD_W-1:0]  qry_start;
      logic [COORD_W-1:0]  qry_end;
      logic                reverse;
      logic [OP_CNT_W-1:0] op_count;
   } cfg_type;

   // classified word passed from front to back
   typedef struct packed {
      logic                is_map;
      logic [OP_IDX_W-1:0] slot;
      logic [LEN_W-1:0]    length;
      logic [KIND_W-1:0]   kind;
      logic                on_ref;
      logic                in_bounds;
      logic [COORD_W-1:0]  target;
   } cmd_type;

   function automatic logic eats_ref(input logic [KIND_W-1:0] k);
      return (k == KIND_M) || (k == KIND_D) || (k == KIND_N) ||
             (k == KIND_EQ) || (k == KIND_X);
   endfunction

   function automatic logic eats_qry(input logic [KIND_W-1:0] k);
      return (k == KIND_M) || (k == KIND_I) || (k == KIND_S) ||
             (k == KIND_EQ) || (k == KIND_X);
   endfunction

endpackage
`default_nettype wire

/* rtl/ccm_front.sv */
// Front end: classifies incoming words, bounds-checks map requests and
// forms the axis offset. Depends on ccm_pkg.
`default_nettype none
module ccm_front (
   input  wire logic                          req_command,
   input  wire logic [ccm_pkg::OP_IDX_W-1:0]  req_op_slot,
   input  wire logic [ccm_pkg::LEN_W-1:0]     req_op_length,
   input  wire logic [ccm_pkg::KIND_W-1:0]    req_op_kind,
   input  wire logic [ccm_pkg::COORD_W-1:0]   req_position,
   input  wire logic                          req_from_reference,
   input  wire ccm_pkg::cfg_type              cfg,
   output ccm_pkg::cmd_type                   cmd
);

   logic                        ref_in, qry_in;
   logic [ccm_pkg::COORD_W-1:0] ref_ofs, qry_ofs;

   always_comb begin
      ref_in  = (req_position >= cfg.ref_start) && (req_position < cfg.ref_end);
      qry_in  = (req_position >= cfg.qry_start) && (req_position < cfg.qry_end);
      ref_ofs = req_position - cfg.ref_start;
      // reverse strand counts down from the last query base
      qry_ofs = cfg.reverse ? (cfg.qry_end - ccm_pkg::COORD_W'(1) - req_position)
                            : (req_position - cfg.qry_start);

      cmd.is_map    = req_command;
      cmd.slot      = req_op_slot;
      cmd.length    = req_op_length;
      cmd.kind      = req_op_kind;
      cmd.on_ref    = req_from_reference;
      cmd.in_bounds = req_from_reference ? ref_in : qry_in;
      cmd.target    = req_from_reference ? ref_ofs : qry_ofs;
   end

endmodule
`default_nettype wire

/* rtl/ccm_queue.sv */
// Short queue of classified words between front and back.
// Depends on ccm_pkg.
`default_nettype none
module ccm_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ccm_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output ccm_pkg::cmd_type      head,
   output logic                  empty
);

   ccm_pkg::cmd_type              entry_ff [ccm_pkg::QUEUE_DEPTH];
   logic [ccm_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ccm_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ccm_pkg::QPTR_W:0]      count_ff, count_in;
   logic                          do_push, do_pop;

   always_comb begin
      full      = (count_ff == (ccm_pkg::QPTR_W+1)'(ccm_pkg::QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (ccm_pkg::QPTR_W+1)'(do_push)
                           - (ccm_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/ccm_back.sv */
// Back end: holds the operation table, walks it for map words and keeps
// the result register. Depends on ccm_pkg.
`default_nettype none
module ccm_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ccm_pkg::cmd_type             head,
   input  wire logic                         cmd_empty,
   output logic                              cmd_pop,
   input  wire ccm_pkg::cfg_type             cfg,
   input  wire logic                         rsp_pop,
   output logic                              rsp_empty,
   output logic [ccm_pkg::COORD_W-1:0]       rsp_mapped_position,
   output logic                              rsp_mapped
);

   localparam int D_W = ccm_pkg::OFS_W + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_SUM, ST_RESULT} state_type;

   typedef struct packed {
      logic [ccm_pkg::LEN_W-1:0]  length;
      logic [ccm_pkg::KIND_W-1:0] kind;
   } entry_type;

   entry_type                     table_mem [ccm_pkg::MAX_OPS];
   entry_type                     rd_entry_ff;

   state_type                     state_ff, state_in;
   logic                          on_ref_ff, on_ref_in;
   logic [ccm_pkg::COORD_W-1:0]   target_ff, target_in;
   logic [ccm_pkg::OP_CNT_W-1:0]  n_ff, n_in;
   logic [ccm_pkg::OP_CNT_W-1:0]  issue_ff, issue_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [ccm_pkg::OFS_W-1:0]     cur_r_ff, cur_r_in, cur_q_ff, cur_q_in;
   logic [ccm_pkg::COORD_W-1:0]   inner_ff, inner_in;
   logic [ccm_pkg::OFS_W-1:0]     other_ff, other_in;
   logic                          ok_ff, ok_in;
   logic [D_W-1:0]                d_ff, d_in;
   logic                          out_vld_ff, out_vld_in;
   logic [ccm_pkg::COORD_W-1:0]   out_pos_ff, out_pos_in;
   logic                          out_mapped_ff, out_mapped_in;

   logic                          cr, cq, hit, issuing, table_we;
   logic [ccm_pkg::OFS_W-1:0]     len_ext, here, step, sum;
   logic [ccm_pkg::COORD_W-1:0]   base, rev_res;
   logic [D_W:0]                  fwd;
   logic                          fwd_ok, rev_ok, use_rev, res_ok;
   logic [ccm_pkg::OP_CNT_W-1:0]  n_cap;

   always_comb begin
      cr      = ccm_pkg::eats_ref(rd_entry_ff.kind);
      cq      = ccm_pkg::eats_qry(rd_entry_ff.kind);
      len_ext = ccm_pkg::OFS_W'(rd_entry_ff.length);
      here    = on_ref_ff ? cur_r_ff : cur_q_ff;
      step    = (on_ref_ff ? cr : cq) ? len_ext : '0;
      sum     = here + step;
      hit     = sum > ccm_pkg::OFS_W'(target_ff);
      issuing = (state_ff == ST_WALK) && (issue_ff < n_ff) && !(rd_vld_ff && hit);

      n_cap = (cfg.op_count > ccm_pkg::OP_CNT_W'(ccm_pkg::MAX_OPS))
              ? ccm_pkg::OP_CNT_W'(ccm_pkg::MAX_OPS) : cfg.op_count;

      // final coordinate from the offset on the other axis
      base    = on_ref_ff ? cfg.qry_start : cfg.ref_start;
      fwd     = (D_W+1)'(base) + (D_W+1)'(d_ff);
      fwd_ok  = (fwd[D_W:ccm_pkg::COORD_W] == '0);
      rev_ok  = d_ff < D_W'(cfg.qry_end);
      rev_res = cfg.qry_end - ccm_pkg::COORD_W'(1) - d_ff[ccm_pkg::COORD_W-1:0];
      use_rev = on_ref_ff && cfg.reverse;
      res_ok  = ok_ff && (use_rev ? rev_ok : fwd_ok);

      cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty;
      table_we = cmd_pop && !head.is_map;
   end

   always_comb begin
      state_in      = state_ff;
      on_ref_in     = on_ref_ff;
      target_in     = target_ff;
      n_in          = n_ff;
      issue_in      = issuing ? issue_ff + 1'b1 : issue_ff;
      rd_vld_in     = issuing;
      cur_r_in      = cur_r_ff;
      cur_q_in      = cur_q_ff;
      inner_in      = inner_ff;
      other_in      = other_ff;
      ok_in         = ok_ff;
      d_in          = d_ff;
      out_vld_in    = out_vld_ff && !rsp_pop;
      out_pos_in    = out_pos_ff;
      out_mapped_in = out_mapped_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && head.is_map) begin
               if (head.in_bounds) begin
                  on_ref_in = head.on_ref;
                  target_in = head.target;
                  n_in      = n_cap;
                  issue_in  = '0;
                  cur_r_in  = '0;
                  cur_q_in  = '0;
                  state_in  = ST_WALK;
               end else begin
                  ok_in    = 1'b0;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_WALK: begin
            if (rd_vld_ff) begin
               if (hit) begin
                  // covering operation found; here never exceeds target
                  inner_in = target_ff - here[ccm_pkg::COORD_W-1:0];
                  other_in = on_ref_ff ? cur_q_ff : cur_r_ff;
                  ok_in    = on_ref_ff ? cq : cr;
                  state_in = ST_SUM;
               end else begin
                  cur_r_in = cr ? cur_r_ff + len_ext : cur_r_ff;
                  cur_q_in = cq ? cur_q_ff + len_ext : cur_q_ff;
               end
            end else if (issue_ff >= n_ff) begin
               ok_in    = 1'b0;
               state_in = ST_RESULT;
            end
         end
         ST_SUM: begin
            d_in     = D_W'(other_ff) + D_W'(inner_ff);
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!out_vld_ff || rsp_pop) begin
               out_vld_in    = 1'b1;
               out_mapped_in = res_ok;
               out_pos_in    = !res_ok ? '0 :
                               use_rev ? rev_res : fwd[ccm_pkg::COORD_W-1:0];
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
      on_ref_ff     <= on_ref_in;
      target_ff     <= target_in;
      n_ff          <= n_in;
      issue_ff      <= issue_in;
      cur_r_ff      <= cur_r_in;
      cur_q_ff      <= cur_q_in;
      inner_ff      <= inner_in;
      other_ff      <= other_in;
      ok_ff         <= ok_in;
      d_ff          <= d_in;
      out_pos_ff    <= out_pos_in;
      out_mapped_ff <= out_mapped_in;
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         table_mem[head.slot] <= '{length: head.length, kind: head.kind};
      end
      rd_entry_ff <= table_mem[issue_ff[ccm_pkg::OP_IDX_W-1:0]];
   end

   assign rsp_empty           = !out_vld_ff;
   assign rsp_mapped_position = out_pos_ff;
   assign rsp_mapped          = out_mapped_ff;

endmodule
`default_nettype wire

/* rtl/cigar_coordinate_mapper.sv */
// Top level of the CIGAR coordinate mapper: configuration registers and the
// front / queue / back chain. Depends on ccm_pkg, ccm_front, ccm_queue, ccm_back.
`default_nettype none
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------------
//  req       push / full          command, op_slot, op_length, op_kind,
//                                 position, from_reference
//  rsp       pop / empty          mapped_position, mapped (one word per map)
//  csr       csr_valid/csr_ready  csr_index, csr_data (ready always high)
//
//  A load word leaves the queue and is written to the operation table at the
//  same edge, in the cycle after acceptance when idle. A map word walks at
//  most op_count table entries in the back end (capped at 256): the walk
//  reads one entry per cycle from the single-read-port table. Out-of-bounds
//  maps skip the walk and go straight to the result state. The front keeps
//  accepting into a two-word queue while the back walks. Synchronous reset
//  clears control state and all configuration registers; the table itself is
//  not cleared. The result register frees on the pop edge.
//
module cigar_coordinate_mapper (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request side
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic                            req_command,
   input  wire logic [ccm_pkg::OP_IDX_W-1:0]    req_op_slot,
   input  wire logic [ccm_pkg::LEN_W-1:0]       req_op_length,
   input  wire logic [ccm_pkg::KIND_W-1:0]      req_op_kind,
   input  wire logic [ccm_pkg::COORD_W-1:0]     req_position,
   input  wire logic                            req_from_reference,
   // response side
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [ccm_pkg::COORD_W-1:0]          rsp_mapped_position,
   output logic                                 rsp_mapped,
   // configuration
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ccm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ccm_pkg::COORD_W-1:0]     csr_data
);

   ccm_pkg::cfg_type cfg_ff, cfg_in;
   ccm_pkg::cmd_type front_cmd, queue_head;
   logic             queue_empty, queue_pop;

   // configuration registers; a write lands at once, so the host must write only
   // while no word is in flight; the block itself does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ccm_pkg::REG_REF_START: cfg_in.ref_start = csr_data;
            ccm_pkg::REG_REF_END:   cfg_in.ref_end   = csr_data;
            ccm_pkg::REG_QRY_START: cfg_in.qry_start = csr_data;
            ccm_pkg::REG_QRY_END:   cfg_in.qry_end   = csr_data;
            ccm_pkg::REG_REVERSE:   cfg_in.reverse   = csr_data[0];
            ccm_pkg::REG_OP_COUNT:  cfg_in.op_count  = csr_data[ccm_pkg::OP_CNT_W-1:0];
            default: ; // unused indexes: word is dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // front: classify and bounds-check
   ccm_front u_front (
      .req_command        (req_command),
      .req_op_slot        (req_op_slot),
      .req_op_length      (req_op_length),
      .req_op_kind        (req_op_kind),
      .req_position       (req_position),
      .req_from_reference (req_from_reference),
      .cfg                (cfg_ff),
      .cmd                (front_cmd)
   );

   // decoupling queue; its full flag is the request-side back-pressure
   ccm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty)
   );

   // back: table writes, table walk and result register
   ccm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (queue_head),
      .cmd_empty           (queue_empty),
      .cmd_pop             (queue_pop),
      .cfg                 (cfg_ff),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_mapped_position (rsp_mapped_position),
      .rsp_mapped          (rsp_mapped)
   );

endmodule
`default_nettype wire

/* verif/tb_cigar_coordinate_mapper.sv */
`timescale 1ns / 100ps
// Self-checking testbench for cigar_coordinate_mapper: directed and random words on the
// req/rsp queues, CSR set-ups between phases. Depends on ccm_pkg and the RTL top level.

module tb_cigar_coordinate_mapper;

   // command codes and kinds that the package leaves out
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAP  = 1'b1;
   localparam logic [ccm_pkg::KIND_W-1:0] KIND_H    = 4'd5;
   localparam logic [ccm_pkg::KIND_W-1:0] KIND_P    = 4'd6;
   localparam logic [ccm_pkg::KIND_W-1:0] KIND_LAST = 4'd15;
   // unused CSR index, writes there must be ignored
   localparam logic [ccm_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   localparam logic [ccm_pkg::COORD_W-1:0] COORD_MAX = '1;
   localparam logic [ccm_pkg::LEN_W-1:0]   LEN_MAX   = '1;

   localparam int STALL_LIMIT     = 4000;  // cycles with no handshake at all
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
   localparam int SETTLE          = 20;    // loads still in flight after last result
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 41;
   localparam int FILL_PHASE      = 2;     // loads the rest of the table
   localparam int PRESSURE_PHASE  = 4;

   // CSR set-up styles
   localparam int SETUP_RANDOM = 0;
   localparam int SETUP_WIDE   = 1;        // full coordinate range, longest walk
   localparam int SETUP_SHUT   = 2;        // empty spans, no operations

   typedef struct {
      logic                         command;
      logic [ccm_pkg::OP_IDX_W-1:0] slot;
      logic [ccm_pkg::LEN_W-1:0]    length;
      logic [ccm_pkg::KIND_W-1:0]   kind;
      logic [ccm_pkg::COORD_W-1:0]  position;
      logic                         from_ref;
   } req_word_type;

   typedef struct {
      logic [ccm_pkg::COORD_W-1:0] position;
      logic                        mapped;
   } lift_type;

   // Mirror of the CIGAR table and CSRs; predicts one lift per map word.
   class liftover_board;
      logic [ccm_pkg::LEN_W-1:0]    op_len  [ccm_pkg::MAX_OPS];
      logic [ccm_pkg::KIND_W-1:0]   op_kind [ccm_pkg::MAX_OPS];
      bit                           written [ccm_pkg::MAX_OPS];
      logic [ccm_pkg::COORD_W-1:0]  ref_start, ref_end, qry_start, qry_end;
      logic                         reverse;
      logic [ccm_pkg::OP_CNT_W-1:0] op_count;
      lift_type                     pending_lifts[$];
      int                           errors;

      function new();
         foreach (op_len[i]) begin
            op_len[i]  = '0;
            op_kind[i] = ccm_pkg::KIND_M;
            written[i] = 1'b0;
         end
         ref_start = '0;
         ref_end   = '0;
         qry_start = '0;
         qry_end   = '0;
         reverse   = 1'b0;
         op_count  = '0;
         errors    = 0;
      endfunction

      function bit uses_ref(logic [ccm_pkg::KIND_W-1:0] k);
         return k == ccm_pkg::KIND_M || k == ccm_pkg::KIND_D || k == ccm_pkg::KIND_N ||
                k == ccm_pkg::KIND_EQ || k == ccm_pkg::KIND_X;
      endfunction

      function bit uses_qry(logic [ccm_pkg::KIND_W-1:0] k);
         return k == ccm_pkg::KIND_M || k == ccm_pkg::KIND_I || k == ccm_pkg::KIND_S ||
                k == ccm_pkg::KIND_EQ || k == ccm_pkg::KIND_X;
      endfunction

      function int walk_len();
         return (op_count > ccm_pkg::OP_CNT_W'(ccm_pkg::MAX_OPS)) ? ccm_pkg::MAX_OPS
                                                                    : int'(op_count);
      endfunction

      // length of the walked operations along one axis
      function bit [63:0] span(bit on_ref);
         bit [63:0] total;
         total = 0;
         for (int i = 0; i < walk_len(); i++)
            if (on_ref ? uses_ref(op_kind[i]) : uses_qry(op_kind[i]))
               total += 64'(op_len[i]);
         return total;
      endfunction

      // contiguous written entries from slot 0
      function int prefix();
         int n;
         n = 0;
         while (n < ccm_pkg::MAX_OPS && written[n]) n++;
         return n;
      endfunction

      function void set_reg(logic [ccm_pkg::CSR_IDX_W-1:0] idx,
                            logic [ccm_pkg::COORD_W-1:0] data);
         case (idx)
            ccm_pkg::REG_REF_START: ref_start = data;
            ccm_pkg::REG_REF_END:   ref_end   = data;
            ccm_pkg::REG_QRY_START: qry_start = data;
            ccm_pkg::REG_QRY_END:   qry_end   = data;
            ccm_pkg::REG_REVERSE:   reverse   = data[0];
            ccm_pkg::REG_OP_COUNT:  op_count  = data[ccm_pkg::OP_CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_word(req_word_type w);
         bit [63:0] tgt, cur_r, cur_q, here, step, inner, d, val;
         bit        cr, cq;
         lift_type  miss;
         if (w.command == CMD_LOAD) begin
            op_len[w.slot]  = w.length;
            op_kind[w.slot] = w.kind;
            written[w.slot] = 1'b1;
            return;
         end
         // default is no mapping; overwritten below when one exists
         miss = '{position: '0, mapped: 1'b0};
         pending_lifts = {pending_lifts, miss};
         if (w.from_ref) begin
            if (w.position < ref_start || w.position >= ref_end) return;
            tgt = 64'(w.position) - 64'(ref_start);
         end else begin
            if (w.position < qry_start || w.position >= qry_end) return;
            tgt = reverse ? 64'(qry_end) - 64'd1 - 64'(w.position)
                          : 64'(w.position) - 64'(qry_start);
         end
         cur_r = 0;
         cur_q = 0;
         for (int i = 0; i < walk_len(); i++) begin
            cr   = uses_ref(op_kind[i]);
            cq   = uses_qry(op_kind[i]);
            here = w.from_ref ? cur_r : cur_q;
            step = (w.from_ref ? cr : cq) ? 64'(op_len[i]) : 64'd0;
            if (here + step > tgt) begin
               inner = tgt - here;
               // deletion / skip seen from the reference, insertion / clip from the query
               if (w.from_ref ? !cq : !cr) return;
               if (w.from_ref) begin
                  d = cur_q + inner;
                  if (!reverse) begin
                     val = 64'(qry_start) + d;
                  end else begin
                     if (qry_end == 0 || d > 64'(qry_end) - 64'd1) return;
                     val = 64'(qry_end) - 64'd1 - d;
                  end
               end else begin
                  val = 64'(ref_start) + cur_r + inner;
               end
               if (val <= 64'(COORD_MAX))
                  pending_lifts[$] = '{position: val[ccm_pkg::COORD_W-1:0], mapped: 1'b1};
               return;
            end
            if (cr) cur_r += 64'(op_len[i]);
            if (cq) cur_q += 64'(op_len[i]);
         end
      endfunction

      function void check_word(logic [ccm_pkg::COORD_W-1:0] pos, logic ok);
         lift_type e;
         if (pending_lifts.size() == 0) begin
            $display("%0t: unexpected rsp word: expected none, actual position %0d mapped %0b",
                     $time, pos, ok);
            errors++;
            return;
         end
         e = pending_lifts[0];
         pending_lifts.delete(0);
         if (ok !== e.mapped) begin
            $display("%0t: mapped: expected %0b, actual %0b", $time, e.mapped, ok);
            errors++;
         end
         if (pos !== e.position) begin
            $display("%0t: mapped_position: expected %0d, actual %0d", $time, e.position, pos);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic                          req_command = CMD_LOAD;
   logic [ccm_pkg::OP_IDX_W-1:0]  req_op_slot = '0;
   logic [ccm_pkg::LEN_W-1:0]     req_op_length = '0;
   logic [ccm_pkg::KIND_W-1:0]    req_op_kind = ccm_pkg::KIND_M;
   logic [ccm_pkg::COORD_W-1:0]   req_position = '0;
   logic                          req_from_reference = 1'b0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [ccm_pkg::COORD_W-1:0]   rsp_mapped_position;
   logic                          rsp_mapped;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [ccm_pkg::CSR_IDX_W-1:0] csr_index = ccm_pkg::REG_REF_START;
   logic [ccm_pkg::COORD_W-1:0]   csr_data = '0;

   liftover_board board = new();

   // knobs shared by the two sides
   bit hold_request  = 1'b0;
   bit calm          = 1'b0;   // no idling at all
   int req_gap_pct   = 25;
   int rsp_stall_pct = 20;
   int idle_cycles   = 0;

   cigar_coordinate_mapper dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_op_slot         (req_op_slot),
      .req_op_length       (req_op_length),
      .req_op_kind         (req_op_kind),
      .req_position        (req_position),
      .req_from_reference  (req_from_reference),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_mapped_position (rsp_mapped_position),
      .rsp_mapped          (rsp_mapped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   // Watchdog: no word moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_cigar_coordinate_mapper: FAIL");
            $finish;
         end
      end
   end

   // Receiver. Outputs are read in the active region of the edge, so they
   // still hold their pre-edge values; rsp_pop gets one NBA per edge.
   initial begin : rsp_side
      int stall;
      stall = 0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            board.check_word(rsp_mapped_position, rsp_mapped);
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !calm && $urandom_range(99) < rsp_stall_pct) begin
            stall = int'($urandom_range(1, 7));
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic req_word_type load_word(logic [ccm_pkg::OP_IDX_W-1:0] slot,
                                              logic [ccm_pkg::LEN_W-1:0] len,
                                              logic [ccm_pkg::KIND_W-1:0] kind);
      req_word_type w;
      w = '{command: CMD_LOAD, slot: slot, length: len, kind: kind,
            position: '0, from_ref: 1'b0};
      return w;
   endfunction

   function automatic req_word_type map_word(logic [ccm_pkg::COORD_W-1:0] pos,
                                             logic from_ref);
      req_word_type w;
      w = '{command: CMD_MAP, slot: '0, length: '0, kind: ccm_pkg::KIND_M,
            position: pos, from_ref: from_ref};
      return w;
   endfunction

   // mostly short operations, now and then huge ones
   function automatic logic [ccm_pkg::LEN_W-1:0] rand_length();
      int r;
      r = $urandom_range(99);
      if (r < 4)       return '0;
      else if (r < 80) return ccm_pkg::LEN_W'($urandom_range(1, 24));
      else if (r < 92) return ccm_pkg::LEN_W'($urandom_range(25, 100000));
      else if (r < 98) return ccm_pkg::LEN_W'($urandom);
      else             return LEN_MAX;
   endfunction

   function automatic logic [ccm_pkg::KIND_W-1:0] rand_kind();
      int r;
      r = $urandom_range(99);
      if (r < 35)      return ccm_pkg::KIND_M;
      else if (r < 45) return ccm_pkg::KIND_I;
      else if (r < 55) return ccm_pkg::KIND_D;
      else if (r < 62) return ccm_pkg::KIND_N;
      else if (r < 68) return ccm_pkg::KIND_S;
      else if (r < 72) return KIND_H;
      else if (r < 76) return KIND_P;
      else if (r < 84) return ccm_pkg::KIND_EQ;
      else if (r < 92) return ccm_pkg::KIND_X;
      else             return ccm_pkg::KIND_W'($urandom_range(9, 15));
   endfunction

   function automatic logic [ccm_pkg::COORD_W-1:0] pick_start();
      int r;
      r = $urandom_range(99);
      if (r < 15)      return '0;
      else if (r < 25) return COORD_MAX - ccm_pkg::COORD_W'($urandom_range(0, 64));
      else if (r < 60) return ccm_pkg::COORD_W'($urandom_range(0, 100000));
      else             return ccm_pkg::COORD_W'($urandom);
   endfunction

   // end of span: mostly just covering the walked operations
   function automatic logic [ccm_pkg::COORD_W-1:0] pick_end(logic [ccm_pkg::COORD_W-1:0] lo,
                                                            bit [63:0] used);
      bit [63:0] e;
      int        r;
      r = $urandom_range(99);
      if (r < 80)      e = 64'(lo) + used + 64'($urandom_range(0, 2));
      else if (r < 88) e = 64'(ccm_pkg::COORD_W'($urandom));
      else if (r < 94) e = 64'(lo);
      else             e = 64'(COORD_MAX);
      return (e > 64'(COORD_MAX)) ? COORD_MAX : e[ccm_pkg::COORD_W-1:0];
   endfunction

   // One req word; an optional gap first. req_full is sampled pre-edge.
   task automatic push_word(req_word_type w);
      if (!calm && $urandom_range(99) < req_gap_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_command        <= w.command;
      req_op_slot        <= w.slot;
      req_op_length      <= w.length;
      req_op_kind        <= w.kind;
      req_position       <= w.position;
      req_from_reference <= w.from_ref;
      req_push           <= 1'b1;
      do @(posedge clock); while (req_full);
      board.note_word(w);
   endtask

   // csr_valid is left high so back-to-back writes need no re-raise
   task automatic write_reg(logic [ccm_pkg::CSR_IDX_W-1:0] idx,
                            logic [ccm_pkg::COORD_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
   endtask

   task automatic configure(logic [ccm_pkg::COORD_W-1:0] rs, logic [ccm_pkg::COORD_W-1:0] re,
                            logic [ccm_pkg::COORD_W-1:0] qs, logic [ccm_pkg::COORD_W-1:0] qe,
                            logic rev, logic [ccm_pkg::OP_CNT_W-1:0] opc);
      write_reg(ccm_pkg::REG_REF_START, rs);
      write_reg(ccm_pkg::REG_REF_END, re);
      write_reg(ccm_pkg::REG_QRY_START, qs);
      write_reg(ccm_pkg::REG_QRY_END, qe);
      write_reg(ccm_pkg::REG_REVERSE, ccm_pkg::COORD_W'(rev));
      write_reg(ccm_pkg::REG_OP_COUNT, ccm_pkg::COORD_W'(opc));
      csr_valid <= 1'b0;
   endtask

   // Quiet point: every lift returned, then time for trailing loads.
   task automatic drain();
      req_push <= 1'b0;
      while (board.pending_lifts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_setup(int mode);
      logic [ccm_pkg::COORD_W-1:0] rs, qs, opc_data;
      int                          p, r;
      p = board.prefix();
      if (mode == SETUP_WIDE) begin
         configure('0, COORD_MAX, '0, COORD_MAX, 1'b1,
                   (p == ccm_pkg::MAX_OPS) ? ccm_pkg::OP_CNT_W'(511)
                                           : ccm_pkg::OP_CNT_W'(p));
      end else if (mode == SETUP_SHUT) begin
         configure(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, '0);
      end else begin
         // the walk never goes past the written part of the table; most walks short
         r = $urandom_range(99);
         if (r < 5)
            opc_data = '0;
         else if (p == ccm_pkg::MAX_OPS && r < 12)
            opc_data = ccm_pkg::COORD_W'(ccm_pkg::MAX_OPS);
         else if (p == ccm_pkg::MAX_OPS && r < 18)
            opc_data = ccm_pkg::COORD_W'($urandom_range(ccm_pkg::MAX_OPS + 1, 511));
         else if (p == ccm_pkg::MAX_OPS && r < 20)
            opc_data = ccm_pkg::COORD_W'(511);
         else
            opc_data = ccm_pkg::COORD_W'($urandom_range(1, (p < 16) ? p : 16));
         // junk above the register width must be dropped
         if ($urandom_range(3) == 0)
            opc_data |= ccm_pkg::COORD_W'($urandom << ccm_pkg::OP_CNT_W);
         write_reg(ccm_pkg::REG_OP_COUNT, opc_data);
         rs = pick_start();
         write_reg(ccm_pkg::REG_REF_START, rs);
         write_reg(ccm_pkg::REG_REF_END, pick_end(rs, board.span(1'b1)));
         qs = pick_start();
         write_reg(ccm_pkg::REG_QRY_START, qs);
         write_reg(ccm_pkg::REG_QRY_END, pick_end(qs, board.span(1'b0)));
         write_reg(ccm_pkg::REG_REVERSE, ccm_pkg::COORD_W'($urandom_range(1)) |
                   (($urandom_range(3) == 0)
                    ? (ccm_pkg::COORD_W'($urandom) & ~ccm_pkg::COORD_W'(1)) : '0));
         csr_valid <= 1'b0;
      end
   endtask

   initial begin : stimulus
      int fill;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // right after reset every span is empty
      push_word(map_word('0, 1'b1));
      drain();

      // forward strand, every kind at least once; ref span 30, query span 32
      configure(31'd1000, 31'd1030, 31'd20, 31'd52, 1'b0, 9'd11);
      push_word(load_word(8'd0, 28'd5, ccm_pkg::KIND_S));
      push_word(load_word(8'd1, 28'd10, ccm_pkg::KIND_M));
      push_word(load_word(8'd2, 28'd3, ccm_pkg::KIND_I));
      push_word(load_word(8'd3, 28'd4, ccm_pkg::KIND_D));
      push_word(load_word(8'd4, 28'd2, ccm_pkg::KIND_N));
      push_word(load_word(8'd5, 28'd5, ccm_pkg::KIND_EQ));
      push_word(load_word(8'd6, 28'd3, ccm_pkg::KIND_X));
      push_word(load_word(8'd7, 28'd2, KIND_H));
      push_word(load_word(8'd8, 28'd1, KIND_P));
      push_word(load_word(8'd9, 28'd7, KIND_LAST));   // unknown kind eats nothing
      push_word(load_word(8'd10, 28'd6, ccm_pkg::KIND_M));
      push_word(map_word(31'd1000, 1'b1));            // first match base
      push_word(map_word(31'd1012, 1'b1));            // inside deletion
      push_word(map_word(31'd1015, 1'b1));            // inside skip
      push_word(map_word(31'd1016, 1'b1));            // '=' run
      push_word(map_word(31'd1029, 1'b1));            // last base
      push_word(map_word(31'd1030, 1'b1));            // at end, excluded
      push_word(map_word(31'd999, 1'b1));             // below start
      push_word(map_word(31'd20, 1'b0));              // soft clip
      push_word(map_word(31'd36, 1'b0));              // insertion
      push_word(map_word(31'd26, 1'b0));
      push_word(map_word(31'd51, 1'b0));
      drain();

      // reverse strand, short query so some lifts fall off it
      write_reg(REG_SPARE, COORD_MAX);
      configure(31'd1000, COORD_MAX, 31'd0, 31'd30, 1'b1, 9'd11);
      push_word(load_word(8'd255, LEN_MAX, KIND_LAST));   // slot not walked
      push_word(map_word(31'd1029, 1'b1));            // beyond query end
      push_word(map_word(31'd1000, 1'b1));
      push_word(map_word(31'd29, 1'b0));              // counts down into the clip
      push_word(map_word(31'd0, 1'b0));
      push_word(map_word(31'd1031, 1'b1));            // past the table
      push_word(map_word(COORD_MAX, 1'b1));
      push_word(map_word(COORD_MAX, 1'b0));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         calm          = (ph >= PHASES - 2);
         req_gap_pct   = calm ? 0 : $urandom_range(2) * 25;
         rsp_stall_pct = calm ? 0 : $urandom_range(2) * 20;

         // grow the written prefix so that op_count can reach further
         if (ph == FILL_PHASE)
            fill = ccm_pkg::MAX_OPS - board.prefix();
         else
            fill = (board.prefix() < ccm_pkg::MAX_OPS) ? $urandom_range(0, 6) : 0;
         for (int k = 0; k < fill; k++)
            push_word(load_word(ccm_pkg::OP_IDX_W'(board.prefix()), rand_length(),
                                rand_kind()));
         if (fill > 0) drain();

         random_setup((ph == 6) ? SETUP_WIDE : (ph == 9) ? SETUP_SHUT : SETUP_RANDOM);

         // receiver goes quiet while the sender keeps offering: queue fills up
         if (ph == PRESSURE_PHASE) begin
            req_gap_pct  = 0;
            hold_request = 1'b1;
         end

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            bit [63:0] lo, hi, p;
            logic      on_ref;
            int        r;
            if ($urandom_range(99) < 60) begin
               on_ref = 1'($urandom_range(1));
               lo = on_ref ? 64'(board.ref_start) : 64'(board.qry_start);
               hi = on_ref ? 64'(board.ref_end) : 64'(board.qry_end);
               r  = $urandom_range(99);
               if (r < 80 && hi > lo) p = lo + ({$urandom, $urandom} % (hi - lo));
               else if (r < 86)       p = lo - 64'd1;
               else if (r < 92)       p = hi;
               else if (r < 95)       p = 64'(COORD_MAX);
               else                   p = 64'($urandom);
               push_word(map_word(p[ccm_pkg::COORD_W-1:0], on_ref));
            end else begin
               push_word(load_word(ccm_pkg::OP_IDX_W'($urandom_range(255)), rand_length(),
                                   rand_kind()));
            end
         end
         drain();
      end

      if (board.errors == 0 && board.pending_lifts.size() == 0)
         $display("tb_cigar_coordinate_mapper: PASS");
      else
         $display("tb_cigar_coordinate_mapper: FAIL");
      $finish;
   end

endmodule
